// File: rtl/tcd_pkg.sv
// Shared constants and helpers for the triangle conformal distortion pipeline.
package tcd_pkg;

  // Square root: radicand and root widths, one root bit per stage.
  localparam int RAD_BITS  = 128;
  localparam int ROOT_BITS = 64;

  // Final division: quotient bits before the round-half-up shift.
  localparam int Q_BITS    = 33;
  localparam int VAL_BITS  = 32;

  // Width of the working value Y and of the bit-length results.
  localparam int Y_BITS    = 127;
  localparam int BL_BITS   = 8;

  // Scale exponents above this always saturate.
  localparam logic signed [7:0] T1_LIMIT = 8'sd28;

  // Position of the highest set bit plus one (0 for zero).
  function automatic logic [BL_BITS-1:0] bit_len(input logic [RAD_BITS-1:0] v);
    logic [BL_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < RAD_BITS; i++) begin
      if (v[i]) begin
        n = BL_BITS'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// File: rtl/triangle_conformal_distortion.sv
// Throughput: one triangle per cycle; the whole pipeline advances together
// and holds while a finished result waits at the output register.
// Depth is set by the 64-stage square root and the 33-stage divider.
// Reset (rst, synchronous) clears all valid bits; no other setup is needed.
module triangle_conformal_distortion #(
  parameter int COORD_BITS    = 21,
  parameter int UV_BITS       = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tri_valid,
  output logic                      tri_ready,
  input  logic [3*COORD_BITS-1:0]   corner0_xyz,
  input  logic [3*COORD_BITS-1:0]   corner1_xyz,
  input  logic [3*COORD_BITS-1:0]   corner2_xyz,
  input  logic [2*UV_BITS-1:0]      corner0_uv,
  input  logic [2*UV_BITS-1:0]      corner1_uv,
  input  logic [2*UV_BITS-1:0]      corner2_uv,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [31:0]               distortion_value,
  output logic                      degenerate,
  output logic                      saturated
);
  import tcd_pkg::*;

  localparam int EW   = COORD_BITS + 1;      // 3D edge
  localparam int FW   = UV_BITS + 1;         // parameter edge
  localparam int PEW  = 2 * EW;              // edge product
  localparam int CRW  = 2 * EW + 1;          // cross component
  localparam int CW   = 4 * EW;              // squared area C
  localparam int GSW  = 2 * EW + 1;          // 3D Gram entries
  localparam int FSW  = 2 * FW;              // 2D Gram entries and det
  localparam int NPW  = GSW + FSW;           // numerator products
  localparam int NW   = NPW + 1;             // signed numerator
  localparam int NCW  = NW - 1;              // clamped numerator
  localparam int DW   = 2 * FW;              // 2|det|
  localparam int YW   = Y_BITS;
  localparam int YW1  = Y_BITS + 1;
  localparam int XW   = Y_BITS + 28;         // Y scaled by at most 2^28
  localparam int XPW  = XW - Q_BITS;         // part above the quotient bits
  localparam int SBW  = YW + DW + CW + 8 + 1;
  localparam int DWPW = DW + ROOT_BITS + 2;
  localparam int S_SHIFT = 2 * (COORD_BITS - 2) - 2 * (UV_BITS - 2) + OUT_FRAC_BITS;

  logic en;

  // Whole pipeline moves unless the output register is full and stalled
  assign en        = !res_valid || res_ready;
  assign tri_ready = en;

  // ---------------- S1: edges ----------------
  logic signed [EW-1:0] e1_c [3];
  logic signed [EW-1:0] e2_c [3];
  logic signed [FW-1:0] f1_c [2];
  logic signed [FW-1:0] f2_c [2];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [FW-1:0] f1 [2];
  logic signed [FW-1:0] f2 [2];
  logic                 v1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_c[k] = EW'(signed'(corner1_xyz[k*COORD_BITS +: COORD_BITS]))
              - EW'(signed'(corner0_xyz[k*COORD_BITS +: COORD_BITS]));
      e2_c[k] = EW'(signed'(corner2_xyz[k*COORD_BITS +: COORD_BITS]))
              - EW'(signed'(corner0_xyz[k*COORD_BITS +: COORD_BITS]));
    end
    for (int k = 0; k < 2; k++) begin
      f1_c[k] = FW'(signed'(corner1_uv[k*UV_BITS +: UV_BITS]))
              - FW'(signed'(corner0_uv[k*UV_BITS +: UV_BITS]));
      f2_c[k] = FW'(signed'(corner2_uv[k*UV_BITS +: UV_BITS]))
              - FW'(signed'(corner0_uv[k*UV_BITS +: UV_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= e1_c;
      e2 <= e2_c;
      f1 <= f1_c;
      f2 <= f2_c;
    end
  end

  // ---------------- S2: narrow products ----------------
  logic signed [PEW-1:0] mx [6];
  logic signed [PEW-1:0] d11 [3];
  logic signed [PEW-1:0] d12 [3];
  logic signed [PEW-1:0] d22 [3];
  logic signed [FSW-1:0] a11 [2];
  logic signed [FSW-1:0] a12 [2];
  logic signed [FSW-1:0] a22 [2];
  logic signed [FSW-1:0] dt0;
  logic signed [FSW-1:0] dt1;
  logic                  v2;

  always_ff @(posedge clk) begin
    if (en) begin
      mx[0] <= PEW'(e1[1]) * PEW'(e2[2]);
      mx[1] <= PEW'(e1[2]) * PEW'(e2[1]);
      mx[2] <= PEW'(e1[2]) * PEW'(e2[0]);
      mx[3] <= PEW'(e1[0]) * PEW'(e2[2]);
      mx[4] <= PEW'(e1[0]) * PEW'(e2[1]);
      mx[5] <= PEW'(e1[1]) * PEW'(e2[0]);
      for (int k = 0; k < 3; k++) begin
        d11[k] <= PEW'(e1[k]) * PEW'(e1[k]);
        d12[k] <= PEW'(e1[k]) * PEW'(e2[k]);
        d22[k] <= PEW'(e2[k]) * PEW'(e2[k]);
      end
      for (int k = 0; k < 2; k++) begin
        a11[k] <= FSW'(f1[k]) * FSW'(f1[k]);
        a12[k] <= FSW'(f1[k]) * FSW'(f2[k]);
        a22[k] <= FSW'(f2[k]) * FSW'(f2[k]);
      end
      dt0 <= FSW'(f1[0]) * FSW'(f2[1]);
      dt1 <= FSW'(f1[1]) * FSW'(f2[0]);
    end
  end

  // ---------------- S3: cross product, Gram entries, det ----------------
  logic signed [CRW-1:0] cr [3];
  logic signed [GSW-1:0] g11, g12, g22;
  logic signed [FSW-1:0] fg11, fg12, fg22, det3;
  logic                  v3;

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= CRW'(mx[0]) - CRW'(mx[1]);
      cr[1] <= CRW'(mx[2]) - CRW'(mx[3]);
      cr[2] <= CRW'(mx[4]) - CRW'(mx[5]);
      g11   <= GSW'(d11[0]) + GSW'(d11[1]) + GSW'(d11[2]);
      g12   <= GSW'(d12[0]) + GSW'(d12[1]) + GSW'(d12[2]);
      g22   <= GSW'(d22[0]) + GSW'(d22[1]) + GSW'(d22[2]);
      fg11  <= a11[0] + a11[1];
      fg12  <= a12[0] + a12[1];
      fg22  <= a22[0] + a22[1];
      det3  <= dt0 - dt1;
    end
  end

  // ---------------- S4-S5: wide products ----------------
  logic signed [2*CRW-1:0] sq [3];
  logic signed [NPW-1:0]   nm0, nm1, nm2;
  logic signed [FSW-1:0]   det4, det5;
  logic                    v4, v5;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    tcd_mul #(.AW(CRW), .BW(CRW)) u_sq (
      .clk(clk), .en(en), .a(cr[k]), .b(cr[k]), .p(sq[k])
    );
  end

  tcd_mul #(.AW(GSW), .BW(FSW)) u_nm0 (.clk(clk), .en(en), .a(g22), .b(fg11), .p(nm0));
  tcd_mul #(.AW(GSW), .BW(FSW)) u_nm1 (.clk(clk), .en(en), .a(g11), .b(fg22), .p(nm1));
  tcd_mul #(.AW(GSW), .BW(FSW)) u_nm2 (.clk(clk), .en(en), .a(g12), .b(fg12), .p(nm2));

  always_ff @(posedge clk) begin
    if (en) begin
      det4 <= det3;
      det5 <= det4;
    end
  end

  // ---------------- S6: C, N, 2|D| ----------------
  logic [CW-1:0]        c6;
  logic signed [NW-1:0] n6;
  logic [DW-1:0]        d2_6;
  logic [FSW-1:0]       det_abs;
  logic                 v6;

  assign det_abs = det5[FSW-1] ? FSW'(-unsigned'(det5)) : unsigned'(det5);

  always_ff @(posedge clk) begin
    if (en) begin
      c6   <= CW'(sq[0]) + CW'(sq[1]) + CW'(sq[2]);
      n6   <= NW'(nm0) + NW'(nm1) - (NW'(nm2) <<< 1);
      d2_6 <= {det_abs[FSW-2:0], 1'b0};
    end
  end

  // ---------------- S7: clamp and bit lengths ----------------
  logic [CW-1:0]      c7;
  logic [NCW-1:0]     nc_c;
  logic [NCW-1:0]     nc7;
  logic [DW-1:0]      d2_7;
  logic [BL_BITS-1:0] blc7, hn7, bd7;
  logic               dg7;
  logic               v7;

  assign nc_c = n6[NW-1] ? '0 : n6[NCW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      c7   <= c6;
      nc7  <= nc_c;
      d2_7 <= d2_6;
      blc7 <= bit_len(RAD_BITS'(c6));
      hn7  <= bit_len(RAD_BITS'(nc_c));
      bd7  <= bit_len(RAD_BITS'(d2_6));
      dg7  <= (c6 == '0);
    end
  end

  // ---------------- S8: guard shift g ----------------
  logic signed [9:0] ga, kk, hh, gb, gm;
  logic [5:0]        g_c;
  logic [5:0]        g8;
  logic [CW-1:0]     c8;
  logic [NCW-1:0]    nc8;
  logic [DW-1:0]     d2_8;
  logic              dg8;
  logic              v8;

  always_comb begin
    ga  = (10'sd127 - signed'({2'b00, blc7})) >>> 1;
    kk  = signed'({2'b00, bd7}) + ((signed'({2'b00, blc7}) + 10'sd1) >>> 1);
    hh  = (signed'({2'b00, hn7}) > kk) ? signed'({2'b00, hn7}) : kk;
    gb  = 10'sd126 - hh;
    gm  = (gb < ga) ? gb : ga;
    g_c = gm[9] ? 6'd0 : gm[5:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g8   <= g_c;
      c8   <= c7;
      nc8  <= nc7;
      d2_8 <= d2_7;
      dg8  <= dg7;
    end
  end

  // ---------------- S9: scale radicand and numerator ----------------
  logic [RAD_BITS-1:0]  rad9;
  logic [YW-1:0]        ng9;
  logic [DW-1:0]        d2_9;
  logic [CW-1:0]        c9;
  logic signed [7:0]    t1_9;
  logic                 dg9;
  logic                 v9;

  always_ff @(posedge clk) begin
    if (en) begin
      rad9 <= RAD_BITS'(c8) << {g8, 1'b0};
      ng9  <= YW'(nc8) << g8;
      d2_9 <= d2_8;
      c9   <= c8;
      t1_9 <= signed'(8'(S_SHIFT + 1) - {2'b00, g8});
      dg9  <= dg8;
    end
  end

  // Valid bits for the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else if (en) begin
      v1 <= tri_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
    end
  end

  // ---------------- square root W = isqrt(C * 4^g) ----------------
  logic [SBW-1:0]       side_in, side_out;
  logic [ROOT_BITS-1:0] root_w;
  logic                 v_w;
  logic [YW-1:0]        ng_w;
  logic [DW-1:0]        d2_w;
  logic [CW-1:0]        c_w;
  logic [7:0]           t1_w;
  logic                 dg_w;

  assign side_in = {ng9, d2_9, c9, t1_9, dg9};
  assign {ng_w, d2_w, c_w, t1_w, dg_w} = side_out;

  tcd_sqrt #(.SBW(SBW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v9), .rad(rad9), .in_side(side_in),
    .out_valid(v_w), .root(root_w), .out_side(side_out)
  );

  // ---------------- 2|D| * W ----------------
  logic signed [DWPW-1:0] dw_p;
  logic [YW-1:0]          ng_m1, ng_m2;
  logic [CW-1:0]          c_m1, c_m2;
  logic [7:0]             t1_m1, t1_m2;
  logic                   dg_m1, dg_m2;
  logic                   v_m1, v_m2;

  tcd_mul #(.AW(DW + 1), .BW(ROOT_BITS + 1)) u_dw (
    .clk(clk), .en(en),
    .a(signed'({1'b0, d2_w})), .b(signed'({1'b0, root_w})), .p(dw_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ng_m1 <= ng_w;  c_m1 <= c_w;  t1_m1 <= t1_w;  dg_m1 <= dg_w;
      ng_m2 <= ng_m1; c_m2 <= c_m1; t1_m2 <= t1_m1; dg_m2 <= dg_m1;
    end
  end

  // ---------------- Y = N*2^g - 2|D|*W, clamped ----------------
  logic [YW1-1:0]    y_diff;
  logic [YW-1:0]     y_y;
  logic [CW-1:0]     c_y;
  logic signed [7:0] t1_y;
  logic              dg_y;
  logic              v_y;

  assign y_diff = {1'b0, ng_m2} - YW1'(dw_p);

  always_ff @(posedge clk) begin
    if (en) begin
      y_y  <= y_diff[YW1-1] ? '0 : y_diff[YW-1:0];
      c_y  <= c_m2;
      t1_y <= signed'(t1_m2);
      dg_y <= dg_m2;
    end
  end

  // ---------------- X = Y * 2^t1 (floor) ----------------
  logic [XW-1:0]  xs;
  logic [7:0]     nsh;
  logic [XPW-1:0] xp_x;
  logic [Q_BITS-1:0] xl_x;
  logic [CW-1:0]  c_x;
  logic           sat_x;
  logic           dg_x;
  logic           v_x;

  always_comb begin
    nsh = 8'(-unsigned'(t1_y));
    xs  = t1_y[7] ? XW'(y_y >> nsh) : (XW'(y_y) << unsigned'(t1_y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_x  <= xs[XW-1:Q_BITS];
      xl_x  <= xs[Q_BITS-1:0];
      c_x   <= c_y;
      sat_x <= t1_y > T1_LIMIT;
      dg_x  <= dg_y;
    end
  end

  // ---------------- divider: X / C, one quotient bit per stage ----------------
  logic [CW-1:0]     dv_r   [0:Q_BITS];
  logic [Q_BITS-1:0] dv_xl  [0:Q_BITS];
  logic [Q_BITS-1:0] dv_q   [0:Q_BITS];
  logic [CW-1:0]     dv_c   [0:Q_BITS];
  logic              dv_sat [0:Q_BITS];
  logic              dv_dg  [0:Q_BITS];
  logic              dv_v   [0:Q_BITS];

  // Entry: upper part must be below C, else the quotient overflows
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= xp_x[CW-1:0];
      dv_xl[0]  <= xl_x;
      dv_q[0]   <= '0;
      dv_c[0]   <= c_x;
      dv_sat[0] <= sat_x || (xp_x >= XPW'(c_x));
      dv_dg[0]  <= dg_x;
    end
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    logic [CW:0] rs;
    logic        ge;

    always_comb begin
      rs = {dv_r[j], dv_xl[j][Q_BITS-1]};
      ge = rs >= {1'b0, dv_c[j]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1]   <= ge ? CW'(rs - {1'b0, dv_c[j]}) : rs[CW-1:0];
        dv_xl[j+1]  <= {dv_xl[j][Q_BITS-2:0], 1'b0};
        dv_q[j+1]   <= {dv_q[j][Q_BITS-2:0], ge};
        dv_c[j+1]   <= dv_c[j];
        dv_sat[j+1] <= dv_sat[j];
        dv_dg[j+1]  <= dv_dg[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // Valid bits for the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0; v_m2 <= 1'b0; v_y <= 1'b0; v_x <= 1'b0; dv_v[0] <= 1'b0;
    end else if (en) begin
      v_m1 <= v_w; v_m2 <= v_m1; v_y <= v_m2; v_x <= v_y; dv_v[0] <= v_x;
    end
  end

  // ---------------- output register: degenerate, round half up, saturate ----------------
  logic [Q_BITS:0] q_inc;
  logic            q_full;

  assign q_inc  = {1'b0, dv_q[Q_BITS]} + 1'b1;
  assign q_full = &dv_q[Q_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv_v[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_dg[Q_BITS]) begin
        distortion_value <= '0;
        degenerate       <= 1'b1;
        saturated        <= 1'b0;
      end else if (dv_sat[Q_BITS] || q_full) begin
        distortion_value <= '1;
        degenerate       <= 1'b0;
        saturated        <= 1'b1;
      end else begin
        distortion_value <= q_inc[VAL_BITS:1];
        degenerate       <= 1'b0;
        saturated        <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/tcd_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module tcd_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LA = (AW + 1) / 2;
  localparam int HA = AW - LA;
  localparam int LB = (BW + 1) / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic [AW-1:0]       a_mag;
  logic [BW-1:0]       b_mag;
  logic [LA+LB-1:0]    pp_ll;
  logic [LA+HB-1:0]    pp_lh;
  logic [HA+LB-1:0]    pp_hl;
  logic [HA+HB-1:0]    pp_hh;
  logic                neg;
  logic [PW-1:0]       sum_mag;

  // Magnitudes; the sign is reapplied after the sum
  always_comb begin
    a_mag = a[AW-1] ? AW'(-unsigned'(a)) : unsigned'(a);
    b_mag = b[BW-1] ? BW'(-unsigned'(b)) : unsigned'(b);
  end

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (LA+LB)'(a_mag[LA-1:0])  * (LA+LB)'(b_mag[LB-1:0]);
      pp_lh <= (LA+HB)'(a_mag[LA-1:0])  * (LA+HB)'(b_mag[BW-1:LB]);
      pp_hl <= (HA+LB)'(a_mag[AW-1:LA]) * (HA+LB)'(b_mag[LB-1:0]);
      pp_hh <= (HA+HB)'(a_mag[AW-1:LA]) * (HA+HB)'(b_mag[BW-1:LB]);
      neg   <= a[AW-1] ^ b[BW-1];
    end
  end

  // Stage 2: aligned sum and sign
  always_comb begin
    sum_mag = (PW'(pp_hh) << (LA + LB)) + (PW'(pp_hl) << LA)
            + (PW'(pp_lh) << LB) + PW'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? signed'(-sum_mag) : signed'(sum_mag);
    end
  end

endmodule

// File: rtl/tcd_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband.
module tcd_sqrt #(
  parameter int SBW = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tcd_pkg::RAD_BITS-1:0] rad,
  input  logic [SBW-1:0]               in_side,
  output logic                         out_valid,
  output logic [tcd_pkg::ROOT_BITS-1:0] root,
  output logic [SBW-1:0]               out_side
);
  import tcd_pkg::*;

  localparam int RW = ROOT_BITS + 3;

  logic [RW-1:0]        rem_s [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] q_s   [0:ROOT_BITS];
  logic [RAD_BITS-1:0]  x_s   [0:ROOT_BITS];
  logic [SBW-1:0]       sb_s  [0:ROOT_BITS];
  logic                 v_s   [0:ROOT_BITS];

  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign x_s[0]   = rad;
  assign sb_s[0]  = in_side;
  assign v_s[0]   = in_valid;

  // Restoring square root: bring down two radicand bits, try 4q+1
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      rem_sh = {rem_s[k][RW-3:0], x_s[k][RAD_BITS-1 -: 2]};
      trial  = RW'({q_s[k], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
        q_s[k+1]   <= {q_s[k][ROOT_BITS-2:0], ge};
        x_s[k+1]   <= {x_s[k][RAD_BITS-3:0], 2'b00};
        sb_s[k+1]  <= sb_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end
  end

  assign out_valid = v_s[ROOT_BITS];
  assign root      = q_s[ROOT_BITS];
  assign out_side  = sb_s[ROOT_BITS];

endmodule

// File: tb/tb.sv
// Testbench for triangle_conformal_distortion: predicts each result and checks it in order.
`timescale 1ns / 100ps

module tb;
  import tcd_pkg::*;

  localparam int CB = 21;
  localparam int UB = 24;
  localparam int FB = 16;
  localparam int SCALE_SH = 2 * (CB - 2) - 2 * (UB - 2) + FB;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [3*CB-1:0] c0, c1, c2;
    logic [2*UB-1:0] q0, q1, q2;
  } tri_t;

  typedef struct {
    logic [31:0] val;
    logic        deg;
    logic        sat;
  } dist_t;

  // Queue of predicted results, oldest first
  class distortion_sb;
    dist_t pending[$];

    function void note(dist_t e);
      pending.push_back(e);
    endfunction

    // Returns an empty string when the beat matches the oldest prediction
    function string check(logic [31:0] v, logic d, logic s);
      dist_t e;
      if (pending.size() == 0) return $sformatf("unexpected result value=%h", v);
      e = pending.pop_front();
      if (v !== e.val || d !== e.deg || s !== e.sat)
        return $sformatf("got value=%h deg=%b sat=%b, want value=%h deg=%b sat=%b",
                         v, d, s, e.val, e.deg, e.sat);
      return "";
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic tri_valid = 0;
  logic tri_ready;
  logic [3*CB-1:0] corner0_xyz = '0, corner1_xyz = '0, corner2_xyz = '0;
  logic [2*UB-1:0] corner0_uv = '0, corner1_uv = '0, corner2_uv = '0;
  logic res_valid;
  logic res_ready = 0;
  logic [31:0] distortion_value;
  logic degenerate, saturated;

  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  distortion_sb sb = new();

  triangle_conformal_distortion dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_ready(tri_ready),
    .corner0_xyz(corner0_xyz), .corner1_xyz(corner1_xyz), .corner2_xyz(corner2_xyz),
    .corner0_uv(corner0_uv), .corner1_uv(corner1_uv), .corner2_uv(corner2_uv),
    .res_valid(res_valid), .res_ready(res_ready),
    .distortion_value(distortion_value), .degenerate(degenerate), .saturated(saturated)
  );

  always #10 clk = ~clk;

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int bitlen(logic [255:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 256; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic logic [255:0] isqrt(logic [255:0] x);
    logic [255:0] res, bitv;
    res = '0;
    bitv = 256'd1 << 126;
    while (bitv != 0 && bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Closed-form singular value gap, scaled and rounded half up
  function automatic dist_t conformal_gap(tri_t t);
    logic signed [21:0] e1[3], e2[3];
    logic signed [24:0] f1[2], f2[2];
    logic signed [63:0] g11, g12, g22, cr[3];
    logic signed [255:0] area2, num, det, f11, f12, f22, det2, wroot, y;
    logic [255:0] yu, cu, q, r, z;
    int blc, g, h, k, t1;
    dist_t o;
    g11 = 0; g12 = 0; g22 = 0;
    o = '{val: '0, deg: 1'b0, sat: 1'b0};
    for (k = 0; k < 3; k++) begin
      e1[k] = (CB+1)'($signed(t.c1[k*CB +: CB])) - (CB+1)'($signed(t.c0[k*CB +: CB]));
      e2[k] = (CB+1)'($signed(t.c2[k*CB +: CB])) - (CB+1)'($signed(t.c0[k*CB +: CB]));
      g11 += 64'(e1[k]) * 64'(e1[k]);
      g12 += 64'(e1[k]) * 64'(e2[k]);
      g22 += 64'(e2[k]) * 64'(e2[k]);
    end
    for (k = 0; k < 2; k++) begin
      f1[k] = (UB+1)'($signed(t.q1[k*UB +: UB])) - (UB+1)'($signed(t.q0[k*UB +: UB]));
      f2[k] = (UB+1)'($signed(t.q2[k*UB +: UB])) - (UB+1)'($signed(t.q0[k*UB +: UB]));
    end
    cr[0] = 64'(e1[1]) * 64'(e2[2]) - 64'(e1[2]) * 64'(e2[1]);
    cr[1] = 64'(e1[2]) * 64'(e2[0]) - 64'(e1[0]) * 64'(e2[2]);
    cr[2] = 64'(e1[0]) * 64'(e2[1]) - 64'(e1[1]) * 64'(e2[0]);
    area2 = 256'(cr[0]) * 256'(cr[0]) + 256'(cr[1]) * 256'(cr[1])
          + 256'(cr[2]) * 256'(cr[2]);
    // zero-area triangle
    if (area2 == 0) begin
      o.deg = 1'b1;
      return o;
    end
    f11 = 256'(f1[0]) * 256'(f1[0]) + 256'(f1[1]) * 256'(f1[1]);
    f22 = 256'(f2[0]) * 256'(f2[0]) + 256'(f2[1]) * 256'(f2[1]);
    f12 = 256'(f1[0]) * 256'(f2[0]) + 256'(f1[1]) * 256'(f2[1]);
    det = 256'(f1[0]) * 256'(f2[1]) - 256'(f1[1]) * 256'(f2[0]);
    num = 256'(g22) * f11 + 256'(g11) * f22 - ((256'(g12) * f12) <<< 1);
    if (num < 0) num = 0;
    det2 = (det < 0) ? -(det <<< 1) : (det <<< 1);
    // guard bits for the square root
    blc = bitlen(area2);
    g = (127 - blc) / 2;
    h = bitlen(num);
    k = bitlen(det2) + (blc + 1) / 2;
    if (k > h) h = k;
    if (126 - h < g) g = 126 - h;
    if (g < 0) g = 0;
    wroot = $signed(isqrt(area2 << (2 * g)));
    y = (num <<< g) - det2 * wroot;
    if (y < 0) y = 0;
    yu = y;
    cu = area2;
    t1 = SCALE_SH - g + 1;
    if (t1 <= 0) begin
      z = (yu >> (-t1)) / cu;
    end else begin
      q = yu / cu;
      r = yu % cu;
      if ((q >> 34) != 0 || t1 > 28) begin
        o.val = '1;
        o.sat = 1'b1;
        return o;
      end
      z = (q << t1) + ((r << t1) / cu);
    end
    z = (z + 256'd1) >> 1;
    if (z > 256'hFFFF_FFFF) begin
      o.val = '1;
      o.sat = 1'b1;
    end else begin
      o.val = z[31:0];
    end
    return o;
  endfunction

  function automatic logic [3*CB-1:0] xyz(int x, int y, int z);
    logic [CB-1:0] a, b, c;
    a = CB'(x); b = CB'(y); c = CB'(z);
    return {c, b, a};
  endfunction

  function automatic logic [2*UB-1:0] uv(int u, int v);
    logic [UB-1:0] a, b;
    a = UB'(u); b = UB'(v);
    return {b, a};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic int srnd(int mag);
    return $urandom_range(2 * mag) - mag;
  endfunction

  // One triangle beat: idle, present, hold until accepted
  task send(tri_t t);
    while ($urandom_range(99) < send_idle) begin
      tri_valid = 0;
      @(negedge clk);
    end
    corner0_xyz = t.c0; corner1_xyz = t.c1; corner2_xyz = t.c2;
    corner0_uv = t.q0; corner1_uv = t.q1; corner2_uv = t.q2;
    tri_valid = 1;
    sb.note(conformal_gap(t));
    do @(posedge clk); while (!tri_ready);
    @(negedge clk);
  endtask

  task send_dir(logic [3*CB-1:0] a, b, c, logic [2*UB-1:0] p, q, r);
    tri_t t;
    t = '{c0: a, c1: b, c2: c, q0: p, q1: q, q2: r};
    send(t);
  endtask

  // Random triangle: raw noise, random power-of-two ranges, or near-conformal maps
  task send_rand();
    tri_t t;
    int mode, m, sh, x[3], y[3], zc[3];
    mode = $urandom_range(9);
    if (mode < 2) begin
      t.c0 = (3*CB)'(rnd64()); t.c1 = (3*CB)'(rnd64()); t.c2 = (3*CB)'(rnd64());
      t.q0 = (2*UB)'(rnd64()); t.q1 = (2*UB)'(rnd64()); t.q2 = (2*UB)'(rnd64());
    end else begin
      m = 1 << $urandom_range(20, 4);
      sh = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        x[i] = srnd(m - 1);
        y[i] = srnd(m - 1);
        zc[i] = (mode < 6) ? srnd(m - 1) : srnd(3);
      end
      t.c0 = xyz(x[0], y[0], zc[0]);
      t.c1 = xyz(x[1], y[1], zc[1]);
      t.c2 = xyz(x[2], y[2], zc[2]);
      if (mode < 6) begin
        m = 1 << $urandom_range(23, 4);
        t.q0 = uv(srnd(m - 1), srnd(m - 1));
        t.q1 = uv(srnd(m - 1), srnd(m - 1));
        t.q2 = uv(srnd(m - 1), srnd(m - 1));
      end else begin
        t.q0 = uv((x[0] << sh) + srnd(7), (y[0] << sh) + srnd(7));
        t.q1 = uv((x[1] << sh) + srnd(7), (y[1] << sh) + srnd(7));
        t.q2 = uv((x[2] << sh) + srnd(7), (y[2] << sh) + srnd(7));
      end
    end
    send(t);
  endtask

  // Result side: random stall at the falling edge
  initial begin
    forever begin
      @(negedge clk);
      res_ready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && res_valid && res_ready) begin
      msg = sb.check(distortion_value, degenerate, saturated);
      if (msg != "") report(msg);
    end
  end

  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int one, uone;
    int idle_s[4] = '{0, 65, 0, 6};
    int idle_r[4] = '{0, 0, 65, 6};
    one = 1 << 19;
    uone = 1 << 22;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zeros, all ones, extremes, conformal, stretched, mirrored,
    // collinear, tiny triangle with huge map
    send_dir('0, '0, '0, '0, '0, '0);
    send_dir('1, '1, '1, '1, '1, '1);
    send_dir(xyz(0, 0, 0), xyz(one, 0, 0), xyz(0, one, 0), uv(0, 0), uv(uone, 0), uv(0, uone));
    send_dir(xyz(0, 0, 0), xyz(one, 0, 0), xyz(0, one, 0),
             uv(0, 0), uv(uone / 2, 0), uv(0, uone / 2));
    send_dir(xyz(0, 0, 0), xyz(one, 0, 0), xyz(0, one, 0),
             uv(0, 0), uv(uone / 4, 0), uv(0, uone / 2));
    send_dir(xyz(0, 0, 0), xyz(one, 0, 0), xyz(0, one, 0), uv(0, 0), uv(0, uone), uv(uone, 0));
    send_dir(xyz(0, 0, 0), xyz(one, one, one), xyz(2 * one, 2 * one, 2 * one),
             uv(0, 0), uv(uone, 0), uv(0, uone));
    send_dir(xyz(0, 0, 0), xyz(1, 0, 0), xyz(0, 1, 0),
             uv(-(1 << 23), -(1 << 23)), uv((1 << 23) - 1, 0), uv(0, (1 << 23) - 1));
    send_dir(xyz(-(1 << 20), -(1 << 20), -(1 << 20)), xyz((1 << 20) - 1, -(1 << 20), 0),
             xyz(0, (1 << 20) - 1, (1 << 20) - 1),
             uv(-(1 << 23), 0), uv((1 << 23) - 1, -(1 << 23)), uv(0, (1 << 23) - 1));
    send_dir(xyz((1 << 20) - 1, 0, 0), xyz(0, (1 << 20) - 1, 0), xyz(0, 0, (1 << 20) - 1),
             uv(0, 0), uv(uone, 0), uv(uone / 2, uone));
    send_dir(xyz(5, 3, 1), xyz(9, -2, 4), xyz(-7, 6, 2), uv(3, 1), uv(-2, 8), uv(5, -5));

    // random phases over the idle mixes
    for (int p = 0; p < 4; p++) begin
      send_idle = idle_s[p];
      recv_stall = idle_r[p];
      repeat (435) send_rand();
    end
    tri_valid = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
